// ===== rtl/assert_macros.svh =====
// assertion macros shared by the outline interpolator modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define POI_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define POI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/poi_pkg.sv =====
// shared types and constants for the polygon outline interpolator
package poi_pkg;

  // default configuration
  localparam int STEPS_DEF      = 40;
  localparam int COORD_BITS_DEF = 24;

  // input operation codes
  localparam logic OP_VERTEX = 1'b0;
  localparam logic OP_CLOSE  = 1'b1;

  // control that travels with one edge job between stages
  typedef struct packed {
    logic vld;
    logic closing;
  } job_ctl_t;

  // divider sequencer
  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_DONE
  } div_state_t;

endpackage

// ===== rtl/polygon_outline_interpolator.sv =====
// top level of the polygon outline interpolator
//
//  channel  dir  handshake             payload
//  in       in   in_valid / in_stall   in_op, in_vert_x, in_vert_y
//  out      out  out_valid / out_stall out_pt_x, out_pt_y, out_run_last, out_contour_done
//
// an edge beat yields STEPS points, one per cycle from the point generator while out_stall
// does not hold the result register; the next edge job is set up while one is stepping
// the first point of an edge reaches the result register through the front's job
// registers, the divider's job load and reciprocal multiply, then the point generator
// beats that yield no points (first vertex, close with no vertex) queue no edge job
// synchronous active-low reset clears contour, valid and state flags; no clearing pass
// out_stall holds the result register; in_stall rises only when an edge job is
// already waiting behind the divider
module polygon_outline_interpolator import poi_pkg::*; #(
  parameter int STEPS      = STEPS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_op,
  input  logic signed [COORD_BITS-1:0] in_vert_x,
  input  logic signed [COORD_BITS-1:0] in_vert_y,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [COORD_BITS-1:0] out_pt_x,
  output logic signed [COORD_BITS-1:0] out_pt_y,
  output logic                         out_run_last,
  output logic                         out_contour_done
);

  localparam int CB = COORD_BITS;
  localparam int RW = $clog2(STEPS) + 1;

  // front to divider
  job_ctl_t             job_ctl;
  logic signed [CB-1:0] job_sx, job_sy;
  logic        [CB-1:0] job_mx, job_my;
  logic                 job_negx, job_negy, job_take;

  // divider to point generator
  job_ctl_t             edge_ctl;
  logic signed [CB-1:0] edge_sx, edge_sy;
  logic        [CB-1:0] edge_qmx, edge_qmy;
  logic        [RW-1:0] edge_rmx, edge_rmy;
  logic                 edge_negx, edge_negy, edge_take;

  // contour state and edge setup
  poi_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_op     (in_op),
    .in_vert_x (in_vert_x),
    .in_vert_y (in_vert_y),
    .job_ctl   (job_ctl),
    .job_sx    (job_sx),
    .job_sy    (job_sy),
    .job_mx    (job_mx),
    .job_my    (job_my),
    .job_negx  (job_negx),
    .job_negy  (job_negy),
    .job_take  (job_take)
  );

  // per-step quotient and remainder of the edge deltas
  poi_div #(
    .STEPS      (STEPS),
    .COORD_BITS (COORD_BITS)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_ctl   (job_ctl),
    .job_sx    (job_sx),
    .job_sy    (job_sy),
    .job_mx    (job_mx),
    .job_my    (job_my),
    .job_negx  (job_negx),
    .job_negy  (job_negy),
    .job_take  (job_take),
    .edge_ctl  (edge_ctl),
    .edge_sx   (edge_sx),
    .edge_sy   (edge_sy),
    .edge_qmx  (edge_qmx),
    .edge_qmy  (edge_qmy),
    .edge_rmx  (edge_rmx),
    .edge_rmy  (edge_rmy),
    .edge_negx (edge_negx),
    .edge_negy (edge_negy),
    .edge_take (edge_take)
  );

  // point stepping and result register
  poi_dda #(
    .STEPS      (STEPS),
    .COORD_BITS (COORD_BITS)
  ) u_dda (
    .clk              (clk),
    .rst_n            (rst_n),
    .edge_ctl         (edge_ctl),
    .edge_sx          (edge_sx),
    .edge_sy          (edge_sy),
    .edge_qmx         (edge_qmx),
    .edge_qmy         (edge_qmy),
    .edge_rmx         (edge_rmx),
    .edge_rmy         (edge_rmy),
    .edge_negx        (edge_negx),
    .edge_negy        (edge_negy),
    .edge_take        (edge_take),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pt_x         (out_pt_x),
    .out_pt_y         (out_pt_y),
    .out_run_last     (out_run_last),
    .out_contour_done (out_contour_done)
  );

endmodule

// ===== rtl/poi_front.sv =====
// input stage: contour state and edge job setup
`include "assert_macros.svh"

module poi_front import poi_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_op,
  input  logic signed [COORD_BITS-1:0] in_vert_x,
  input  logic signed [COORD_BITS-1:0] in_vert_y,
  output job_ctl_t                     job_ctl,
  output logic signed [COORD_BITS-1:0] job_sx,
  output logic signed [COORD_BITS-1:0] job_sy,
  output logic        [COORD_BITS-1:0] job_mx,
  output logic        [COORD_BITS-1:0] job_my,
  output logic                         job_negx,
  output logic                         job_negy,
  input  logic                         job_take
);

  localparam int CB = COORD_BITS;

  logic signed [CB-1:0] first_x_r, first_y_r, prev_x_r, prev_y_r;
  logic                 have_r, have_nxt;
  logic                 job_vld_r, job_vld_nxt;
  logic                 job_cls_r;
  logic signed [CB-1:0] job_sx_r, job_sy_r;
  logic        [CB-1:0] job_mx_r, job_my_r;
  logic                 job_negx_r, job_negy_r;

  logic                 in_acc;
  logic                 emit;
  logic        [CB-1:0] end_x, end_y;
  logic        [CB:0]   dx, dy, dx_abs, dy_abs;

  // one pending job; a new beat waits only while it is still held
  assign in_stall = job_vld_r && !job_take;
  assign in_acc   = in_valid && !in_stall;
  assign emit     = in_acc && have_r;

  // edge end point and signed difference to the previous vertex
  assign end_x  = (in_op == OP_CLOSE) ? first_x_r : in_vert_x;
  assign end_y  = (in_op == OP_CLOSE) ? first_y_r : in_vert_y;
  assign dx     = {end_x[CB-1], end_x} - {prev_x_r[CB-1], prev_x_r};
  assign dy     = {end_y[CB-1], end_y} - {prev_y_r[CB-1], prev_y_r};
  assign dx_abs = dx[CB] ? ((~dx) + {{CB{1'b0}}, 1'b1}) : dx;
  assign dy_abs = dy[CB] ? ((~dy) + {{CB{1'b0}}, 1'b1}) : dy;

  // contour flag and job occupancy
  always_comb begin
    have_nxt = have_r;
    if (in_acc) begin
      have_nxt = (in_op == OP_VERTEX);
    end
    job_vld_nxt = job_vld_r;
    if (emit) begin
      job_vld_nxt = 1'b1;
    end else if (job_take) begin
      job_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r    <= 1'b0;
      job_vld_r <= 1'b0;
      first_x_r <= '0;
      first_y_r <= '0;
      prev_x_r  <= '0;
      prev_y_r  <= '0;
    end else begin
      have_r    <= have_nxt;
      job_vld_r <= job_vld_nxt;
      // vertex bookkeeping
      if (in_acc && in_op == OP_VERTEX) begin
        prev_x_r <= in_vert_x;
        prev_y_r <= in_vert_y;
        if (!have_r) begin
          first_x_r <= in_vert_x;
          first_y_r <= in_vert_y;
        end
      end
    end
  end

  // job payload
  always_ff @(posedge clk) begin
    if (emit) begin
      job_sx_r   <= prev_x_r;
      job_sy_r   <= prev_y_r;
      job_mx_r   <= dx_abs[CB-1:0];
      job_my_r   <= dy_abs[CB-1:0];
      job_negx_r <= dx[CB];
      job_negy_r <= dy[CB];
      job_cls_r  <= (in_op == OP_CLOSE);
    end
  end

  assign job_ctl.vld     = job_vld_r;
  assign job_ctl.closing = job_cls_r;
  assign job_sx          = job_sx_r;
  assign job_sy          = job_sy_r;
  assign job_mx          = job_mx_r;
  assign job_my          = job_my_r;
  assign job_negx        = job_negx_r;
  assign job_negy        = job_negy_r;

  `POI_ASSERT_NEXT(a_close_ends_contour, in_acc && in_op == OP_CLOSE, !have_r,
    "contour still open after close beat")

endmodule

// ===== rtl/poi_div.sv =====
// constant divider: splits edge magnitudes into step quotient and remainder
`include "assert_macros.svh"

module poi_div import poi_pkg::*; #(
  parameter int STEPS      = STEPS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  job_ctl_t                            job_ctl,
  input  logic signed [COORD_BITS-1:0]        job_sx,
  input  logic signed [COORD_BITS-1:0]        job_sy,
  input  logic        [COORD_BITS-1:0]        job_mx,
  input  logic        [COORD_BITS-1:0]        job_my,
  input  logic                                job_negx,
  input  logic                                job_negy,
  output logic                                job_take,
  output job_ctl_t                            edge_ctl,
  output logic signed [COORD_BITS-1:0]        edge_sx,
  output logic signed [COORD_BITS-1:0]        edge_sy,
  output logic        [COORD_BITS-1:0]        edge_qmx,
  output logic        [COORD_BITS-1:0]        edge_qmy,
  output logic        [$clog2(STEPS):0]       edge_rmx,
  output logic        [$clog2(STEPS):0]       edge_rmy,
  output logic                                edge_negx,
  output logic                                edge_negy,
  input  logic                                edge_take
);

  localparam int CB  = COORD_BITS;
  localparam int RW  = $clog2(STEPS) + 1;
  localparam int SH  = $clog2(STEPS);
  localparam int PRW = 2 * CB + SH + 1;
  // ceil(2^(CB+SH) / STEPS): exact quotient for every CB-bit magnitude
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << (CB + SH)) + 64'(STEPS) - 64'd1) / 64'(STEPS);
  localparam logic [CB:0]   RECIP   = RECIP_FULL[CB:0];
  localparam logic [CB-1:0] STEPS_C = CB'(STEPS);

  div_state_t st_r, st_nxt;
  logic        [CB-1:0]  mx_r, my_r, qx_r, qy_r;
  logic signed [CB-1:0]  sx_r, sy_r;
  logic                  negx_r, negy_r, cls_r;
  logic        [PRW-1:0] prod_x, prod_y;
  logic        [CB-1:0]  back_x, back_y, rem_x, rem_y;

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      DIV_IDLE: begin
        if (job_ctl.vld) st_nxt = DIV_RUN;
      end
      DIV_RUN: begin
        st_nxt = DIV_DONE;
      end
      DIV_DONE: begin
        if (edge_take) st_nxt = job_ctl.vld ? DIV_RUN : DIV_IDLE;
      end
      default: st_nxt = DIV_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    job_take         = job_ctl.vld &&
                       (st_r == DIV_IDLE || (st_r == DIV_DONE && edge_take));
    edge_ctl.vld     = (st_r == DIV_DONE);
    edge_ctl.closing = cls_r;
  end

  // quotient by reciprocal multiplication, captured in the run state
  assign prod_x = PRW'(mx_r) * PRW'(RECIP);
  assign prod_y = PRW'(my_r) * PRW'(RECIP);

  // remainder from the registered quotient
  assign back_x = qx_r * STEPS_C;
  assign back_y = qy_r * STEPS_C;
  assign rem_x  = mx_r - back_x;
  assign rem_y  = my_r - back_y;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= DIV_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  // edge job capture, then quotient capture
  always_ff @(posedge clk) begin
    if (job_take) begin
      mx_r   <= job_mx;
      my_r   <= job_my;
      sx_r   <= job_sx;
      sy_r   <= job_sy;
      negx_r <= job_negx;
      negy_r <= job_negy;
      cls_r  <= job_ctl.closing;
    end else if (st_r == DIV_RUN) begin
      qx_r <= prod_x[CB+SH +: CB];
      qy_r <= prod_y[CB+SH +: CB];
    end
  end

  assign edge_sx   = sx_r;
  assign edge_sy   = sy_r;
  assign edge_qmx  = qx_r;
  assign edge_qmy  = qy_r;
  assign edge_rmx  = rem_x[RW-1:0];
  assign edge_rmy  = rem_y[RW-1:0];
  assign edge_negx = negx_r;
  assign edge_negy = negy_r;

  `POI_ASSERT_NEXT(a_done_holds, st_r == DIV_DONE && !edge_take,
    st_r == DIV_DONE && $stable(qx_r) && $stable(mx_r),
    "finished quotient changed before hand-off")
  `POI_ASSERT_IMPL(a_rem_below_steps, st_r == DIV_DONE,
    rem_x < STEPS_C && rem_y < STEPS_C, "remainder not below the step count")

endmodule

// ===== rtl/poi_dda.sv =====
// point generator: steps along one edge and drives the result register
`include "assert_macros.svh"

module poi_dda import poi_pkg::*; #(
  parameter int STEPS      = STEPS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  job_ctl_t                     edge_ctl,
  input  logic signed [COORD_BITS-1:0] edge_sx,
  input  logic signed [COORD_BITS-1:0] edge_sy,
  input  logic        [COORD_BITS-1:0] edge_qmx,
  input  logic        [COORD_BITS-1:0] edge_qmy,
  input  logic        [$clog2(STEPS):0] edge_rmx,
  input  logic        [$clog2(STEPS):0] edge_rmy,
  input  logic                         edge_negx,
  input  logic                         edge_negy,
  output logic                         edge_take,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [COORD_BITS-1:0] out_pt_x,
  output logic signed [COORD_BITS-1:0] out_pt_y,
  output logic                         out_run_last,
  output logic                         out_contour_done
);

  localparam int CB = COORD_BITS;
  localparam int RW = $clog2(STEPS) + 1;
  localparam int JW = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam logic [RW:0] STEPS_W = (RW+1)'(STEPS);

  logic                 act_r, act_nxt;
  logic                 out_vld_r, out_vld_nxt;
  logic [JW-1:0]        j_r;
  logic signed [CB-1:0] sx_r, sy_r;
  logic        [CB-1:0] qmx_r, qmy_r, qx_r, qy_r;
  logic        [RW-1:0] rmx_r, rmy_r, rx_r, ry_r;
  logic                 negx_r, negy_r, cls_r;
  logic signed [CB-1:0] pt_x_r, pt_y_r;
  logic                 run_last_r, done_r;

  logic                 adv, is_last;
  logic        [RW:0]   rsum_x, rsum_y, rdif_x, rdif_y;
  logic                 wrap_x, wrap_y;
  logic        [CB:0]   offx, offy, px_full, py_full;

  // advance when an edge is active and the result register is free
  assign is_last   = (j_r == JW'(STEPS - 1));
  assign adv       = act_r && (!out_vld_r || !out_stall);
  assign edge_take = edge_ctl.vld && (!act_r || (adv && is_last));

  always_comb begin
    act_nxt = act_r;
    if (edge_take) begin
      act_nxt = 1'b1;
    end else if (adv && is_last) begin
      act_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r;
    if (adv) begin
      out_vld_nxt = 1'b1;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  // fractional carry: remainder steps by rm, wraps at the step count
  assign rsum_x = {1'b0, rx_r} + {1'b0, rmx_r};
  assign rsum_y = {1'b0, ry_r} + {1'b0, rmy_r};
  assign wrap_x = (rsum_x >= STEPS_W);
  assign wrap_y = (rsum_y >= STEPS_W);
  assign rdif_x = wrap_x ? (rsum_x - STEPS_W) : rsum_x;
  assign rdif_y = wrap_y ? (rsum_y - STEPS_W) : rsum_y;

  // current point: start plus signed offset
  assign offx    = negx_r ? ((~{1'b0, qx_r}) + {{CB{1'b0}}, 1'b1}) : {1'b0, qx_r};
  assign offy    = negy_r ? ((~{1'b0, qy_r}) + {{CB{1'b0}}, 1'b1}) : {1'b0, qy_r};
  assign px_full = {sx_r[CB-1], sx_r} + offx;
  assign py_full = {sy_r[CB-1], sy_r} + offy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r     <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      act_r     <= act_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // edge registers and step accumulators
  always_ff @(posedge clk) begin
    if (edge_take) begin
      sx_r   <= edge_sx;
      sy_r   <= edge_sy;
      qmx_r  <= edge_qmx;
      qmy_r  <= edge_qmy;
      rmx_r  <= edge_rmx;
      rmy_r  <= edge_rmy;
      negx_r <= edge_negx;
      negy_r <= edge_negy;
      cls_r  <= edge_ctl.closing;
      qx_r   <= '0;
      qy_r   <= '0;
      rx_r   <= '0;
      ry_r   <= '0;
      j_r    <= '0;
    end else if (adv) begin
      qx_r <= qx_r + qmx_r + CB'(wrap_x);
      qy_r <= qy_r + qmy_r + CB'(wrap_y);
      rx_r <= rdif_x[RW-1:0];
      ry_r <= rdif_y[RW-1:0];
      j_r  <= j_r + 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (adv) begin
      pt_x_r     <= px_full[CB-1:0];
      pt_y_r     <= py_full[CB-1:0];
      run_last_r <= is_last;
      done_r     <= is_last && cls_r;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_pt_x         = pt_x_r;
  assign out_pt_y         = pt_y_r;
  assign out_run_last     = run_last_r;
  assign out_contour_done = done_r;

  `POI_ASSERT_NEXT(a_last_point_marked, adv && is_last, out_vld_r && run_last_r,
    "final point of an edge not marked")
  `POI_ASSERT_IMPL(a_done_on_last, out_vld_r && done_r, run_last_r,
    "contour end flagged on a point that is not the last of its edge")

endmodule

// ===== verif/tb.sv =====
// testbench for the polygon outline interpolator: directed and random contours
`timescale 1ns / 100ps

module tb import poi_pkg::*; ();

  localparam int CW = COORD_BITS_DEF;
  localparam int STEPS = STEPS_DEF;
  localparam int IDLE_LIMIT = 4000;
  localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};

  typedef struct {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic run_last;
    logic contour_done;
  } outline_pt_t;

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_LONG} stall_mode_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_op = OP_VERTEX;
  logic signed [CW-1:0] in_vert_x = '0;
  logic signed [CW-1:0] in_vert_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [CW-1:0] out_pt_x;
  logic signed [CW-1:0] out_pt_y;
  logic out_run_last;
  logic out_contour_done;

  // predictor state of the contour being built
  logic signed [CW-1:0] contour_first_x = '0;
  logic signed [CW-1:0] contour_first_y = '0;
  logic signed [CW-1:0] contour_prev_x = '0;
  logic signed [CW-1:0] contour_prev_y = '0;
  logic contour_open = 1'b0;

  outline_pt_t expected_pts[$];
  outline_pt_t head_pt;
  int errors = 0;
  int burst_left = 0;
  int idle_cycles = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int stall_run = 0;

  polygon_outline_interpolator dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_vert_x        (in_vert_x),
    .in_vert_y        (in_vert_y),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pt_x         (out_pt_x),
    .out_pt_y         (out_pt_y),
    .out_run_last     (out_run_last),
    .out_contour_done (out_contour_done)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // queue the points of one edge, quotient truncated toward zero
  task automatic push_edge(logic signed [CW-1:0] sx, logic signed [CW-1:0] sy,
                           logic signed [CW-1:0] ex, logic signed [CW-1:0] ey,
                           logic closing);
    longint dx;
    longint dy;
    longint px;
    longint py;
    outline_pt_t pt;
    dx = longint'(ex) - longint'(sx);
    dy = longint'(ey) - longint'(sy);
    for (int j = 0; j < STEPS; j++) begin
      px = longint'(sx) + (longint'(j) * dx) / longint'(STEPS);
      py = longint'(sy) + (longint'(j) * dy) / longint'(STEPS);
      pt.x = px[CW-1:0];
      pt.y = py[CW-1:0];
      pt.run_last = (j == STEPS - 1);
      pt.contour_done = (j == STEPS - 1) && closing;
      expected_pts.insert(expected_pts.size(), pt);
    end
  endtask

  // outline predictor: update contour state, queue the points a beat causes
  task automatic predict_outline(logic op, logic signed [CW-1:0] x, logic signed [CW-1:0] y);
    if (op == OP_VERTEX) begin
      if (!contour_open) begin
        contour_first_x = x;
        contour_first_y = y;
        contour_open = 1'b1;
      end else begin
        push_edge(contour_prev_x, contour_prev_y, x, y, 1'b0);
      end
      contour_prev_x = x;
      contour_prev_y = y;
    end else if (contour_open) begin
      push_edge(contour_prev_x, contour_prev_y, contour_first_x, contour_first_y, 1'b1);
      contour_open = 1'b0;
    end
  endtask

  // send one beat, predict on acceptance, then pace the sender in bursts
  task automatic send_beat(logic op, logic signed [CW-1:0] x, logic signed [CW-1:0] y);
    int gap;
    in_valid <= 1'b1;
    in_op <= op;
    in_vert_x <= x;
    in_vert_y <= y;
    do @(posedge clk); while (in_stall);
    predict_outline(op, x, y);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 30) : $urandom_range(0, 4);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(0, 12);
    end
  endtask

  // hold the sender off until every queued point has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_pts.size() != 0);
  endtask

  // coordinate near a given point, at an extreme, or anywhere
  function automatic logic signed [CW-1:0] pick_coord(logic signed [CW-1:0] near);
    int d;
    logic signed [CW-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = CW'($urandom);
      4, 5: begin
        d = $urandom_range(0, 200) - 100;
        v = near + CW'(d);
      end
      6: begin
        case ($urandom_range(0, 3))
          0: v = COORD_MAX;
          1: v = COORD_MIN;
          2: v = '0;
          default: v = '1;
        endcase
      end
      default: begin
        d = $urandom_range(0, 80) - 40;
        v = near + CW'(d);
      end
    endcase
    return v;
  endfunction

  // extremes of the coordinate range and closes with no vertex
  task automatic test_directed_extremes();
    send_beat(OP_CLOSE, CW'($urandom), CW'($urandom));
    send_beat(OP_VERTEX, '0, '0);
    send_beat(OP_VERTEX, COORD_MAX, COORD_MAX);
    send_beat(OP_VERTEX, COORD_MIN, COORD_MIN);
    send_beat(OP_VERTEX, COORD_MAX, COORD_MIN);
    send_beat(OP_VERTEX, COORD_MIN, COORD_MAX);
    send_beat(OP_CLOSE, CW'($urandom), CW'($urandom));
    send_beat(OP_CLOSE, COORD_MAX, COORD_MIN);
  endtask

  // a contour of one vertex closes as repeated copies of it
  task automatic test_single_vertex();
    send_beat(OP_VERTEX, CW'(-1), CW'(1));
    send_beat(OP_CLOSE, '0, '0);
  endtask

  // small negative and positive steps exercise truncation toward zero
  task automatic test_truncation();
    send_beat(OP_VERTEX, CW'(5), CW'(-5));
    send_beat(OP_VERTEX, CW'(-34), CW'(44));
    send_beat(OP_VERTEX, CW'(-33), CW'(43));
    send_beat(OP_VERTEX, COORD_MAX, '0);
    send_beat(OP_CLOSE, '1, '1);
  endtask

  // random contours, stray closes, and unclosed contours that run on
  task automatic test_random_contours(int n_items);
    int sent;
    int nverts;
    bit paused;
    sent = 0;
    paused = 0;
    while (sent < n_items) begin
      if (!contour_open && $urandom_range(0, 9) == 0)
        send_beat(OP_CLOSE, CW'($urandom), CW'($urandom));
      nverts = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 6);
      repeat (nverts) send_beat(OP_VERTEX, pick_coord(contour_prev_x),
                                pick_coord(contour_prev_y));
      sent += nverts;
      if ($urandom_range(0, 9) != 0) begin
        send_beat(OP_CLOSE, CW'($urandom), CW'($urandom));
        sent++;
      end
      if (!paused && sent >= n_items / 2) begin
        wait_drained();
        paused = 1;
      end
    end
  endtask

  // receiver stall pattern, switching between modes
  always @(posedge clk) begin
    if (stall_run == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      stall_run <= $urandom_range(8, 80);
    end else begin
      stall_run <= stall_run - 1;
    end
    case (stall_mode)
      STALL_NONE: out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= ($urandom_range(0, 15) == 0) ? ~out_stall : out_stall;
    endcase
  end

  function automatic void check_field(string name, logic signed [63:0] expv,
                                      logic signed [63:0] actv);
    if (expv !== actv) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expv, actv);
      errors++;
    end
  endfunction

  // compare each accepted result beat with the oldest expected point
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_pts.size() == 0) begin
        $display("%0t: unexpected point, expected none, actual x=%0d y=%0d",
                 $time, out_pt_x, out_pt_y);
        errors++;
      end else begin
        head_pt = expected_pts.pop_front();
        check_field("pt_x", 64'(head_pt.x), 64'(out_pt_x));
        check_field("pt_y", 64'(head_pt.y), 64'(out_pt_y));
        check_field("run_last", 64'(head_pt.run_last), 64'(out_run_last));
        check_field("contour_done", 64'(head_pt.contour_done), 64'(out_contour_done));
      end
    end
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d points outstanding",
               $time, idle_cycles, expected_pts.size());
      $display("tb: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // reset, tests in turn, drain, final verdict
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_extremes();
    test_single_vertex();
    test_truncation();
    wait_drained();
    test_random_contours(200);
    wait_drained();
    repeat (24) @(posedge clk);
    if (errors == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/poi_pkg.sv
rtl/poi_front.sv
rtl/poi_div.sv
rtl/poi_dda.sv
rtl/polygon_outline_interpolator.sv
verif/tb.sv
